// ===== src/pfa_pkg.sv =====
package pfa_pkg;

    localparam int NUM_FRAMES = 64;
    localparam int OWNER_BITS = 16;
    localparam int AGE_W      = 32;

    localparam int ADDR_W  = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int CNT_W   = $clog2(NUM_FRAMES + 1);
    localparam int PAGES_W = 7;
    localparam int CMP_W   = ((CNT_W > PAGES_W) ? CNT_W : PAGES_W) + 1;
    localparam int ENTRY_W = OWNER_BITS + AGE_W;

    localparam int PROC_W = 16;
    localparam int KIND_W = 2;
    localparam int HELD_W = 7;
    localparam int EVIC_W = 7;
    localparam int TOT_W  = 32;

    localparam int S_FIELDS_W = PROC_W + PAGES_W;
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 1 + HELD_W + EVIC_W + TOT_W + TOT_W;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    typedef logic [OWNER_BITS-1:0] owner_t;
    typedef logic [AGE_W-1:0]      age_t;
    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [CMP_W-1:0]      cmp_t;
    typedef logic [ENTRY_W-1:0]    entry_t;
    typedef logic [TOT_W-1:0]      tot_t;
    typedef logic [M_DATA_W-1:0]   m_data_t;

    typedef logic [KIND_W-1:0] kind_t;
    localparam kind_t KIND_TICK    = 2'd0;
    localparam kind_t KIND_ALLOC   = 2'd1;
    localparam kind_t KIND_RELEASE = 2'd2;

    typedef enum logic [5:0] {
        PASS_TICK  = 6'b000001,
        PASS_COUNT = 6'b000010,
        PASS_FREE  = 6'b000100,
        PASS_VICT  = 6'b001000,
        PASS_ACT   = 6'b010000,
        PASS_REL   = 6'b100000
    } pass_t;

    typedef struct packed {
        logic match;
        logic victim;
        logic older;
        age_t age_inc;
    } alu_res_t;

endpackage

// ===== src/pfa_ram.sv =====
module pfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/pfa_alu.sv =====
module pfa_alu (
    input  logic              owned,
    input  logic              active,
    input  pfa_pkg::entry_t   entry,
    input  pfa_pkg::owner_t   who,
    input  logic              found,
    input  pfa_pkg::age_t     best_age,
    output pfa_pkg::alu_res_t res
);

    pfa_pkg::owner_t owner;
    pfa_pkg::age_t   age;
    logic            same;

    assign owner = entry[pfa_pkg::OWNER_BITS-1:0];
    assign age   = entry[pfa_pkg::ENTRY_W-1:pfa_pkg::OWNER_BITS];
    assign same  = (owner == who);

    always_comb
    begin
        res.match   = owned && same;
        res.victim  = owned && !active && !same;
        res.older   = !found || (age > best_age);
        res.age_inc = (age == '1) ? age : age + pfa_pkg::age_t'(1);
    end

endmodule

// ===== src/page_frame_allocator_age_evict_top.sv =====
// Channel   Direction  Handshake             Payload
// s_*       in         s_tvalid / s_tready   tuser: kind; tdata: proc_id, pages_needed
// m_*       out        m_tvalid / m_tready   tdata: granted, frames_held, evictions, totals
//
// Every transaction is served by passes over the frame table, one entry per cycle
// through the owner/age RAM read port.
// A tick or release takes one pass, an allocate two or three passes plus one per eviction.
// Reset frees every frame at once through per-frame owned and active flags.
// A new transaction is taken once the previous one has reached the output register,
// which holds its result until the downstream side takes it.
module page_frame_allocator_age_evict_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pfa_pkg::S_DATA_W-1:0]    s_tdata,  // proc_id, pages_needed
    input  logic [pfa_pkg::KIND_W-1:0]      s_tuser,  // kind
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pfa_pkg::M_DATA_W-1:0]    m_tdata   // granted, frames_held, evictions,
                                                      // paged_in_total, paged_out_total
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_NEXT = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t                   state_reg, state_next;
    pfa_pkg::pass_t           pass_reg, pass_next;
    pfa_pkg::kind_t           kind_reg, kind_next;
    pfa_pkg::owner_t          who_reg, who_next;
    logic [pfa_pkg::PAGES_W-1:0] want_reg, want_next;
    pfa_pkg::cnt_t            have_reg, have_next;
    pfa_pkg::cnt_t            evict_reg, evict_next;
    logic                     grant_reg, grant_next;
    pfa_pkg::cnt_t            idx_reg, idx_next;
    pfa_pkg::addr_t           proc_idx_reg, proc_idx_next;
    logic                     proc_vld_reg, proc_vld_next;
    logic                     found_reg, found_next;
    pfa_pkg::age_t            best_age_reg, best_age_next;
    pfa_pkg::addr_t           best_idx_reg, best_idx_next;
    logic [pfa_pkg::NUM_FRAMES-1:0] owned_reg, owned_next;
    logic [pfa_pkg::NUM_FRAMES-1:0] active_reg, active_next;
    pfa_pkg::tot_t            in_tot_reg, in_tot_next;
    pfa_pkg::tot_t            out_tot_reg, out_tot_next;
    logic                     mvalid_reg, mvalid_next;
    pfa_pkg::m_data_t         mdata_reg, mdata_next;

    logic              ram_we;
    pfa_pkg::addr_t    ram_waddr;
    pfa_pkg::entry_t   ram_wdata;
    logic              ram_re;
    pfa_pkg::entry_t   ram_rdata;
    pfa_pkg::alu_res_t alu_res;
    logic              have_ge_want;
    logic              have1_ge_want;

    pfa_ram #(
        .WIDTH(pfa_pkg::ENTRY_W),
        .DEPTH(pfa_pkg::NUM_FRAMES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_reg[pfa_pkg::ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    pfa_alu u_alu (
        .owned    (owned_reg[proc_idx_reg]),
        .active   (active_reg[proc_idx_reg]),
        .entry    (ram_rdata),
        .who      (who_reg),
        .found    (found_reg),
        .best_age (best_age_reg),
        .res      (alu_res)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

    assign have_ge_want  = pfa_pkg::cmp_t'(have_reg) >= pfa_pkg::cmp_t'(want_reg);
    assign have1_ge_want = (pfa_pkg::cmp_t'(have_reg) + pfa_pkg::cmp_t'(1))
                           >= pfa_pkg::cmp_t'(want_reg);

    always_comb
    begin
        state_next    = state_reg;
        pass_next     = pass_reg;
        kind_next     = kind_reg;
        who_next      = who_reg;
        want_next     = want_reg;
        have_next     = have_reg;
        evict_next    = evict_reg;
        grant_next    = grant_reg;
        idx_next      = idx_reg;
        proc_idx_next = proc_idx_reg;
        proc_vld_next = proc_vld_reg;
        found_next    = found_reg;
        best_age_next = best_age_reg;
        best_idx_next = best_idx_reg;
        owned_next    = owned_reg;
        active_next   = active_reg;
        in_tot_next   = in_tot_reg;
        out_tot_next  = out_tot_reg;
        mvalid_next   = mvalid_reg;
        mdata_next    = mdata_reg;
        ram_we        = 1'b0;
        ram_waddr     = proc_idx_reg;
        ram_wdata     = {pfa_pkg::age_t'(0), who_reg};
        ram_re        = 1'b0;

        if (mvalid_reg && m_tready)
        begin
            mvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    kind_next     = s_tuser;
                    who_next      = pfa_pkg::owner_t'(s_tdata[pfa_pkg::PROC_W-1:0]);
                    want_next     = s_tdata[pfa_pkg::S_FIELDS_W-1:pfa_pkg::PROC_W];
                    have_next     = '0;
                    evict_next    = '0;
                    grant_next    = 1'b0;
                    idx_next      = '0;
                    proc_vld_next = 1'b0;
                    found_next    = 1'b0;
                    best_age_next = '0;
                    state_next    = S_SCAN;
                    if (s_tuser == pfa_pkg::KIND_TICK)
                    begin
                        pass_next = pfa_pkg::PASS_TICK;
                    end
                    else if (s_tuser == pfa_pkg::KIND_RELEASE)
                    begin
                        pass_next = pfa_pkg::PASS_REL;
                    end
                    else
                    begin
                        pass_next = pfa_pkg::PASS_COUNT;
                    end
                end
            end

            S_SCAN:
            begin
                proc_vld_next = 1'b0;
                if (idx_reg < pfa_pkg::cnt_t'(pfa_pkg::NUM_FRAMES))
                begin
                    ram_re        = 1'b1;
                    proc_idx_next = idx_reg[pfa_pkg::ADDR_W-1:0];
                    proc_vld_next = 1'b1;
                    idx_next      = idx_reg + pfa_pkg::cnt_t'(1);
                end
                if (proc_vld_reg)
                begin
                    case (pass_reg)
                        pfa_pkg::PASS_TICK:
                        begin
                            if (owned_reg[proc_idx_reg])
                            begin
                                ram_we    = 1'b1;
                                ram_wdata = {alu_res.age_inc,
                                             ram_rdata[pfa_pkg::OWNER_BITS-1:0]};
                            end
                            if (alu_res.match)
                            begin
                                have_next = have_reg + pfa_pkg::cnt_t'(1);
                            end
                        end
                        pfa_pkg::PASS_COUNT:
                        begin
                            if (alu_res.match)
                            begin
                                have_next = have_reg + pfa_pkg::cnt_t'(1);
                            end
                        end
                        pfa_pkg::PASS_FREE:
                        begin
                            if (!owned_reg[proc_idx_reg] && !have_ge_want)
                            begin
                                owned_next[proc_idx_reg]  = 1'b1;
                                active_next[proc_idx_reg] = 1'b0;
                                ram_we      = 1'b1;
                                in_tot_next = in_tot_reg + pfa_pkg::tot_t'(1);
                                have_next   = have_reg + pfa_pkg::cnt_t'(1);
                            end
                        end
                        pfa_pkg::PASS_VICT:
                        begin
                            if (alu_res.victim && alu_res.older)
                            begin
                                found_next    = 1'b1;
                                best_age_next =
                                    ram_rdata[pfa_pkg::ENTRY_W-1:pfa_pkg::OWNER_BITS];
                                best_idx_next = proc_idx_reg;
                            end
                        end
                        pfa_pkg::PASS_ACT:
                        begin
                            if (alu_res.match)
                            begin
                                active_next[proc_idx_reg] = 1'b1;
                            end
                        end
                        pfa_pkg::PASS_REL:
                        begin
                            if (alu_res.match)
                            begin
                                owned_next[proc_idx_reg]  = 1'b0;
                                active_next[proc_idx_reg] = 1'b0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    if (proc_idx_reg == pfa_pkg::addr_t'(pfa_pkg::NUM_FRAMES - 1))
                    begin
                        state_next = S_NEXT;
                    end
                end
            end

            S_NEXT:
            begin
                idx_next      = '0;
                proc_vld_next = 1'b0;
                found_next    = 1'b0;
                best_age_next = '0;
                state_next    = S_SCAN;
                case (pass_reg)
                    pfa_pkg::PASS_COUNT:
                    begin
                        if (kind_reg != pfa_pkg::KIND_ALLOC)
                        begin
                            state_next = S_DONE;
                        end
                        else if (have_ge_want)
                        begin
                            pass_next = pfa_pkg::PASS_ACT;
                        end
                        else
                        begin
                            pass_next = pfa_pkg::PASS_FREE;
                        end
                    end
                    pfa_pkg::PASS_FREE:
                    begin
                        pass_next = have_ge_want ? pfa_pkg::PASS_ACT : pfa_pkg::PASS_VICT;
                    end
                    pfa_pkg::PASS_VICT:
                    begin
                        if (!found_reg)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            ram_we                    = 1'b1;
                            ram_waddr                 = best_idx_reg;
                            active_next[best_idx_reg] = 1'b0;
                            out_tot_next = out_tot_reg + pfa_pkg::tot_t'(1);
                            in_tot_next  = in_tot_reg + pfa_pkg::tot_t'(1);
                            evict_next   = evict_reg + pfa_pkg::cnt_t'(1);
                            have_next    = have_reg + pfa_pkg::cnt_t'(1);
                            if (have1_ge_want)
                            begin
                                pass_next = pfa_pkg::PASS_ACT;
                            end
                        end
                    end
                    pfa_pkg::PASS_ACT:
                    begin
                        grant_next = 1'b1;
                        state_next = S_DONE;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_DONE:
            begin
                if (!mvalid_reg || m_tready)
                begin
                    mvalid_next = 1'b1;
                    mdata_next  = pfa_pkg::m_data_t'({out_tot_reg, in_tot_reg,
                                      evict_reg[pfa_pkg::EVIC_W-1:0],
                                      have_reg[pfa_pkg::HELD_W-1:0], grant_reg});
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pass_reg     <= pfa_pkg::PASS_COUNT;
            proc_vld_reg <= 1'b0;
            idx_reg      <= '0;
            owned_reg    <= '0;
            active_reg   <= '0;
            in_tot_reg   <= '0;
            out_tot_reg  <= '0;
            mvalid_reg   <= 1'b0;
            have_reg     <= '0;
            evict_reg    <= '0;
            found_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pass_reg     <= pass_next;
            proc_vld_reg <= proc_vld_next;
            idx_reg      <= idx_next;
            owned_reg    <= owned_next;
            active_reg   <= active_next;
            in_tot_reg   <= in_tot_next;
            out_tot_reg  <= out_tot_next;
            mvalid_reg   <= mvalid_next;
            have_reg     <= have_next;
            evict_reg    <= evict_next;
            found_reg    <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        who_reg      <= who_next;
        want_reg     <= want_next;
        grant_reg    <= grant_next;
        proc_idx_reg <= proc_idx_next;
        best_age_reg <= best_age_next;
        best_idx_reg <= best_idx_next;
        mdata_reg    <= mdata_next;
    end

    // Every eviction also hands the frame to the requester.
    a_evict_le_have: assert property (@(posedge clk) disable iff (!rst_n)
        evict_reg <= have_reg)
        else $error("eviction count exceeds frames held");

    a_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        (in_tot_reg == $past(in_tot_reg)) ||
        (in_tot_reg == $past(in_tot_reg) + pfa_pkg::tot_t'(1)))
        else $error("paged-in total moved by more than one");

    a_out_with_in: assert property (@(posedge clk) disable iff (!rst_n)
        (out_tot_reg != $past(out_tot_reg)) |-> (in_tot_reg != $past(in_tot_reg)))
        else $error("eviction without a matching page-in");

endmodule
